>>> design/tsp_pkg.sv
// ---------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the trigger-rate servo positioner
// Field widths, fixed-point constants and the status bundle that the serial
// arithmetic units hand back to their controller.
// ---------------------------------------------------------------------------
package tsp_pkg;

  // Field and datapath widths
  localparam int TRIG_W     = 8;   // trigger value, deadzone, span
  localparam int RATE_W     = 10;  // max_rate register
  localparam int SPEED_W    = 10;  // per-trigger speed in deg/s
  localparam int DT_W       = 8;   // capped elapsed time in ms
  localparam int ELAPSED_W  = 16;  // raw elapsed time field
  localparam int DEG_W      = 8;   // whole-degree angles and command
  localparam int ANGLE_W    = 18;  // angle in millidegrees
  localparam int PROD_W     = 18;  // (trigger - deadzone) * max_rate
  localparam int SUM_W      = 20;  // signed angle + speed * dt
  localparam int RND_W      = 19;  // angle + half a degree
  localparam int RND_QW     = 9;   // quotient bits of the rounding divide
  localparam int MDEG_W     = 10;  // width of the constant 1000
  localparam int IN_TDATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Fixed-point constants
  localparam logic [MDEG_W-1:0]  MDEG_PER_DEG = 10'd1000;
  localparam logic [ANGLE_W-1:0] SEND_MDEG    = 18'd500;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET  = 18'd90000;
  localparam logic [TRIG_W-1:0]  TRIG_FULL    = 8'd255;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, result valid and held from here on
  } unit_stat_t;

  // Whole degrees to millidegrees: d * 1000 = d * 1024 - d * 16 - d * 8
  function automatic logic [ANGLE_W-1:0] to_mdeg(input logic [DEG_W-1:0] d);
    logic [ANGLE_W-1:0] ext;
    begin
      ext = ANGLE_W'(d);
      return (ext << 10) - (ext << 4) - (ext << 3);
    end
  endfunction

endpackage

>>> design/tsp_serial_mul.sv
// ---------------------------------------------------------------------------
// tsp_serial_mul: bit-serial shift-add multiplier
// Consumes one bit of the serial operand per cycle, LSB first, and shifts
// the partial product right.
// ---------------------------------------------------------------------------
module tsp_serial_mul
  import tsp_pkg::*;
#(
  parameter int AW = 10,   // parallel operand width
  parameter int BW = 8     // serial operand width, one bit per cycle
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output unit_stat_t         stat,
  output logic [AW+BW-1:0]   product
);

  localparam int CW = $clog2(BW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] a_r;
  logic [AW-1:0] hi_r;
  logic [BW-1:0] lo_r;
  logic [AW:0]   sum_nxt;

  // Add the parallel operand when the current serial bit is set
  assign sum_nxt = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : {(AW+1){1'b0}});

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift the product right one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum_nxt[AW:1];
      lo_r <= {sum_nxt[0], lo_r[BW-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {hi_r, lo_r};

endmodule

>>> design/tsp_serial_div.sv
// ---------------------------------------------------------------------------
// tsp_serial_div: bit-serial restoring divider
// Produces one quotient bit per cycle, MSB first. The caller guarantees the
// quotient fits in QW bits, so the upper dividend bits preload the
// remainder and only QW steps are run.
// ---------------------------------------------------------------------------
module tsp_serial_div
  import tsp_pkg::*;
#(
  parameter int DW = 18,   // dividend width
  parameter int VW = 8,    // divisor width
  parameter int QW = 10    // quotient bits, one per cycle
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [VW-1:0]  divisor,
  output unit_stat_t     stat,
  output logic [QW-1:0]  quotient
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] dvs_r;
  logic [VW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [VW:0]   shift_nxt;
  logic [VW:0]   diff_nxt;
  logic          fits_nxt;

  // Trial subtract of the divisor from the shifted remainder
  assign shift_nxt = {rem_r, quo_r[QW-1]};
  assign fits_nxt  = (shift_nxt >= {1'b0, dvs_r});
  assign diff_nxt  = shift_nxt - {1'b0, dvs_r};

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and a shared dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= VW'(dividend >> QW);
      quo_r <= dividend[QW-1:0];
    end else if (busy_r) begin
      rem_r <= fits_nxt ? diff_nxt[VW-1:0] : shift_nxt[VW-1:0];
      quo_r <= {quo_r[QW-2:0], fits_nxt};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

>>> design/tsp_trig_speed.sv
// ---------------------------------------------------------------------------
// tsp_trig_speed: trigger-to-speed converter
// Computes (trigger - deadzone) * max_rate / (255 - deadzone) with a serial
// multiply followed by a serial divide; a gated trigger yields zero.
// ---------------------------------------------------------------------------
module tsp_trig_speed
  import tsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               en,       // trigger above a usable deadzone
  input  logic [TRIG_W-1:0]  excess,   // trigger - deadzone
  input  logic [RATE_W-1:0]  rate,
  input  logic [TRIG_W-1:0]  span,     // 255 - deadzone
  output unit_stat_t         stat,
  output logic [SPEED_W-1:0] speed
);

  logic               en_r;
  logic [TRIG_W-1:0]  span_r;
  unit_stat_t         mul_stat;
  unit_stat_t         div_stat;
  logic [PROD_W-1:0]  prod;
  logic [SPEED_W-1:0] quo;

  // Hold the gate and divisor for the length of the run
  always_ff @(posedge clk) begin
    if (start) begin
      en_r   <= en;
      span_r <= span;
    end
  end

  tsp_serial_mul #(
    .AW (RATE_W),
    .BW (TRIG_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .a       (rate),
    .b       (excess),
    .stat    (mul_stat),
    .product (prod)
  );

  // Product is below span * 1024, so a 10-bit quotient always fits
  tsp_serial_div #(
    .DW (PROD_W),
    .VW (TRIG_W),
    .QW (SPEED_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_stat.done),
    .dividend (prod),
    .divisor  (span_r),
    .stat     (div_stat),
    .quotient (quo)
  );

  assign stat.busy = mul_stat.busy | div_stat.busy | mul_stat.done;
  assign stat.done = div_stat.done;
  assign speed     = en_r ? quo : '0;

endmodule

>>> design/trigger_rate_servo_positioner.sv
// ---------------------------------------------------------------------------
// trigger_rate_servo_positioner: servo angle from buttons and triggers
//
// in_* channel: one control sample per beat (fields in in_tdata). The angle
// is held in millidegrees; buttons snap it to the limits, triggers move it
// at a speed scaled by max_rate and the capped elapsed time, then it is
// clamped. out_* channel: an 8-bit servo command in whole degrees, sent on
// the first sample and whenever the angle has moved 500 millidegrees or
// more from the last command. A link-down sample is dropped.
// The next sample is taken the cycle after the command is loaded, or once the
// send check finds nothing to send. The serial chain does the arithmetic:
// a multiply and a divide for both triggers in parallel, a speed*dt multiply
// and a rounding divide by 1000. With no trigger above the deadzone the
// chain starts at the rounding divide, which runs only when a command is sent.
// One output register parts the two sides: a sample is accepted while a
// command waits; a second command waits in its own state until out_tready.
// cfg_*: write-only registers, to be written by the user only while the block is idle; the block does not enforce it.
// Reset (rst_n low, synchronous) restores register defaults, the angle to
// 90 degrees and forgets the last command sent.
// ---------------------------------------------------------------------------
module trigger_rate_servo_positioner
  import tsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // [0] link_up, [1] open_button, [2] close_button, [10:3] open_trigger,
  // [18:11] close_trigger, [34:19] elapsed_ms, [39:35] zero
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] servo_degrees
  output logic [DEG_W-1:0]      out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_CAP    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPEED,
    S_SCALE,
    S_CLAMP,
    S_CHECK,
    S_ROUND,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [DEG_W-1:0]    min_r;
  logic [DEG_W-1:0]    max_r;
  logic [RATE_W-1:0]   rate_r;
  logic [TRIG_W-1:0]   dz_r;
  logic [DT_W-1:0]     cap_r;
  logic [ANGLE_W-1:0]  angle_r;
  logic [ANGLE_W-1:0]  last_r;
  logic                sent_r;
  logic [DEG_W-1:0]    out_data_r;
  logic                out_valid_r;
  logic [DT_W-1:0]     dt_r;
  logic                neg_r;
  logic [SUM_W-1:0]    sum_r;

  // Input fields
  logic                 link_up;
  logic                 open_button;
  logic                 close_button;
  logic [TRIG_W-1:0]    open_trigger;
  logic [TRIG_W-1:0]    close_trigger;
  logic [ELAPSED_W-1:0] elapsed_ms;

  logic                 in_acc;
  logic [DT_W-1:0]      dt_nxt;
  logic [ANGLE_W-1:0]   min_mdeg;
  logic [ANGLE_W-1:0]   max_mdeg;
  logic [ANGLE_W-1:0]   snap_nxt;
  logic                 open_hot;
  logic                 close_hot;
  logic                 dz_live;
  logic [TRIG_W-1:0]    span;
  logic                 trig_go;
  unit_stat_t           spd_o_stat;
  unit_stat_t           spd_c_stat;
  logic [SPEED_W-1:0]   spd_o;
  logic [SPEED_W-1:0]   spd_c;
  logic                 neg_nxt;
  logic [SPEED_W-1:0]   mag_nxt;
  logic                 mul_go;
  unit_stat_t           mul_stat;
  logic [ANGLE_W-1:0]   prod;
  logic [SUM_W-1:0]     sum_nxt;
  logic [ANGLE_W-1:0]   clamp_nxt;
  logic [ANGLE_W-1:0]   diff;
  logic                 send;
  logic                 rnd_go;
  logic [RND_W-1:0]     rnd_dividend;
  unit_stat_t           rnd_stat;
  logic [RND_QW-1:0]    rnd_q;
  logic                 out_free;
  logic                 out_load;

  // Unpack the sample
  assign link_up       = in_tdata[0];
  assign open_button   = in_tdata[1];
  assign close_button  = in_tdata[2];
  assign open_trigger  = in_tdata[10:3];
  assign close_trigger = in_tdata[18:11];
  assign elapsed_ms    = in_tdata[34:19];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;

  // Cap elapsed time; snap to a limit, close button wins
  assign dt_nxt   = (elapsed_ms > ELAPSED_W'(cap_r)) ? cap_r : elapsed_ms[DT_W-1:0];
  assign min_mdeg = to_mdeg(min_r);
  assign max_mdeg = to_mdeg(max_r);
  assign snap_nxt = close_button ? min_mdeg : (open_button ? max_mdeg : angle_r);

  // Trigger gating
  assign open_hot  = (open_trigger > dz_r);
  assign close_hot = (close_trigger > dz_r);
  assign dz_live   = (dz_r != TRIG_FULL);
  assign span      = TRIG_FULL - dz_r;
  assign trig_go   = in_acc & link_up & (open_hot | close_hot);

  tsp_trig_speed u_spd_open (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (trig_go),
    .en     (open_hot & dz_live),
    .excess (open_trigger - dz_r),
    .rate   (rate_r),
    .span   (span),
    .stat   (spd_o_stat),
    .speed  (spd_o)
  );

  tsp_trig_speed u_spd_close (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (trig_go),
    .en     (close_hot & dz_live),
    .excess (close_trigger - dz_r),
    .rate   (rate_r),
    .span   (span),
    .stat   (spd_c_stat),
    .speed  (spd_c)
  );

  // Net speed as sign and magnitude
  assign neg_nxt = (spd_c > spd_o);
  assign mag_nxt = neg_nxt ? (spd_c - spd_o) : (spd_o - spd_c);
  assign mul_go  = (state_r == S_SPEED) & spd_o_stat.done;

  tsp_serial_mul #(
    .AW (SPEED_W),
    .BW (DT_W)
  ) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_go),
    .a       (mag_nxt),
    .b       (dt_r),
    .stat    (mul_stat),
    .product (prod)
  );

  // Move the angle by speed * dt, then clamp (low bound checked first)
  assign sum_nxt   = neg_r ? (SUM_W'(angle_r) - SUM_W'(prod))
                           : (SUM_W'(angle_r) + SUM_W'(prod));
  assign clamp_nxt = ($signed(sum_r) < $signed(SUM_W'(min_mdeg))) ? min_mdeg :
                     ($signed(sum_r) > $signed(SUM_W'(max_mdeg))) ? max_mdeg :
                     sum_r[ANGLE_W-1:0];

  // Send decision and rounding to whole degrees
  assign diff         = (angle_r >= last_r) ? (angle_r - last_r) : (last_r - angle_r);
  assign send         = !sent_r || (diff >= SEND_MDEG);
  assign rnd_go       = (state_r == S_CHECK) & send;
  assign rnd_dividend = RND_W'(angle_r) + RND_W'(SEND_MDEG);

  tsp_serial_div #(
    .DW (RND_W),
    .VW (MDEG_W),
    .QW (RND_QW)
  ) u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rnd_go),
    .dividend (rnd_dividend),
    .divisor  (MDEG_PER_DEG),
    .stat     (rnd_stat),
    .quotient (rnd_q)
  );

  assign out_free = !out_valid_r || out_tready;
  assign out_load = out_free &
                    (((state_r == S_ROUND) & rnd_stat.done) | (state_r == S_EMIT));

  // Sequencer, configuration, angle state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= 8'd5;
      max_r       <= 8'd175;
      rate_r      <= 10'd540;
      dz_r        <= 8'd12;
      cap_r       <= 8'd50;
      angle_r     <= ANGLE_RESET;
      last_r      <= '0;
      sent_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_ANGLE: min_r  <= cfg_wdata[DEG_W-1:0];
          CFG_MAX_ANGLE: max_r  <= cfg_wdata[DEG_W-1:0];
          CFG_MAX_RATE:  rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_DEADZONE:  dz_r   <= cfg_wdata[TRIG_W-1:0];
          CFG_DT_CAP:    cap_r  <= cfg_wdata[DT_W-1:0];
          default: ;
        endcase
      end

      // Load a finished command, or drop the output beat once taken
      if (out_load) begin
        out_data_r  <= rnd_q[DEG_W-1:0];
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc && link_up) begin
            angle_r <= snap_nxt;
            state_r <= (open_hot || close_hot) ? S_SPEED : S_CHECK;
          end
        end
        S_SPEED: begin
          if (spd_o_stat.done) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mul_stat.done) begin
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          angle_r <= clamp_nxt;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (send) begin
            last_r  <= angle_r;
            sent_r  <= 1'b1;
            state_r <= S_ROUND;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_ROUND: begin
          if (rnd_stat.done) begin
            state_r <= out_free ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Hold per-sample operands
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r <= dt_nxt;
    end
    if (mul_go) begin
      neg_r <= neg_nxt;
    end
    if (state_r == S_SCALE && mul_stat.done) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // Both speed units run in lockstep
  assert property (@(posedge clk) disable iff (!rst_n)
    spd_o_stat.done == spd_c_stat.done)
    else $error("trigger speed units out of step");

  // Angle never leaves the range reachable by snap or clamp
  assert property (@(posedge clk) disable iff (!rst_n)
    angle_r <= to_mdeg(TRIG_FULL))
    else $error("angle above 255 degrees");

  // A command on the output implies the send state was recorded
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> sent_r)
    else $error("command out without send record");

  // The scale product only completes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> state_r == S_SCALE)
    else $error("scale multiply finished outside its state");

  // A finished rounding divide is either emitted at once or parked
  assert property (@(posedge clk) disable iff (!rst_n)
    (rnd_stat.done && !out_free) |=> (state_r == S_EMIT))
    else $error("rounded command lost while output stalled");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench of the trigger-rate servo positioner
// Drives control samples through the in_* stream and compares every servo
// command on out_* with a local model of the angle integrator, or with the
// value a row fixes. A short table covers buttons, trigger extremes, deadzone
// edges and odd register settings. Random samples then follow under several
// register settings and three patterns of stalls on both streams.
// ---------------------------------------------------------------------------
module tb;
  import tsp_pkg::*;

  localparam int DRAIN_CYCLES      = 100;
  localparam int ITEMS_PER_SETTING = 52;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_ANGLE = 3'd0,
    REG_MAX_ANGLE = 3'd1,
    REG_MAX_RATE  = 3'd2,
    REG_DEADZONE  = 3'd3,
    REG_DT_CAP    = 3'd4
  } reg_idx_t;

  // Packed so that link_up lands in bit 0 of in_tdata
  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [TRIG_W-1:0]    close_trigger;
    logic [TRIG_W-1:0]    open_trigger;
    logic                 close_button;
    logic                 open_button;
    logic                 link_up;
  } sample_t;

  typedef struct {
    bit               is_reg;
    reg_idx_t         idx;
    int unsigned      value;
    sample_t          s;
    bit               typed;
    logic [DEG_W-1:0] deg;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  // [0] link_up, [1] open_button, [2] close_button, [10:3] open_trigger,
  // [18:11] close_trigger, [34:19] elapsed_ms, [39:35] zero
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [7:0] servo_degrees
  logic [DEG_W-1:0]      out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Fixed expectation riding along with the beat on in_tdata
  bit                    beat_typed = 1'b0;
  logic [DEG_W-1:0]      beat_deg = '0;

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 87;
  int unsigned mismatch_count = 0;
  logic [DEG_W-1:0] pending_degrees[$];

  // Register copies and servo state of the model
  logic [DEG_W-1:0]   min_deg = 8'd5;
  logic [DEG_W-1:0]   max_deg = 8'd175;
  logic [RATE_W-1:0]  rate_dps = 10'd540;
  logic [TRIG_W-1:0]  dead_zone = 8'd12;
  logic [DT_W-1:0]    dt_cap = 8'd50;
  logic [ANGLE_W-1:0] pos_mdeg = 18'd90000;
  logic [ANGLE_W-1:0] sent_mdeg = '0;
  bit                 sent_any = 1'b0;

  trigger_rate_servo_positioner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Speed of one trigger in deg/s; zero at or below the deadzone
  function automatic int unsigned trigger_rate(logic [TRIG_W-1:0] t);
    int unsigned span;
    if (t <= dead_zone || dead_zone >= TRIG_FULL) return 0;
    span = 32'(TRIG_FULL) - 32'(dead_zone);
    return ((32'(t) - 32'(dead_zone)) * 32'(rate_dps)) / span;
  endfunction

  // Advance the angle by one sample and decide whether a command goes out
  function automatic void advance_servo(input sample_t s, output bit emit,
                                        output logic [DEG_W-1:0] deg);
    int unsigned dt;
    longint net, lo, hi, a, diff;
    emit = 1'b0;
    deg = '0;
    dt = (s.elapsed_ms > dt_cap) ? 32'(dt_cap) : 32'(s.elapsed_ms);
    if (!s.link_up) return;
    if (s.open_button) pos_mdeg = ANGLE_W'(32'(max_deg) * 32'(MDEG_PER_DEG));
    if (s.close_button) pos_mdeg = ANGLE_W'(32'(min_deg) * 32'(MDEG_PER_DEG));
    if (s.open_trigger > dead_zone || s.close_trigger > dead_zone) begin
      net = longint'(trigger_rate(s.open_trigger)) - longint'(trigger_rate(s.close_trigger));
      lo = longint'(min_deg) * longint'(MDEG_PER_DEG);
      hi = longint'(max_deg) * longint'(MDEG_PER_DEG);
      a = longint'(pos_mdeg) + net * longint'(dt);
      if (a < lo) a = lo;
      else if (a > hi) a = hi;
      pos_mdeg = ANGLE_W'(a);
    end
    diff = longint'(pos_mdeg) - longint'(sent_mdeg);
    if (diff < 0) diff = -diff;
    if (!sent_any || diff >= longint'(SEND_MDEG)) begin
      emit = 1'b1;
      deg = DEG_W'((32'(pos_mdeg) + 32'(SEND_MDEG)) / 32'(MDEG_PER_DEG));
      sent_mdeg = pos_mdeg;
      sent_any = 1'b1;
    end
  endfunction

  function automatic void apply_reg(reg_idx_t idx, int unsigned value);
    case (idx)
      REG_MIN_ANGLE: min_deg = DEG_W'(value);
      REG_MAX_ANGLE: max_deg = DEG_W'(value);
      REG_MAX_RATE:  rate_dps = RATE_W'(value);
      REG_DEADZONE:  dead_zone = TRIG_W'(value);
      REG_DT_CAP:    dt_cap = DT_W'(value);
      default: ;
    endcase
  endfunction

  function automatic plan_row_t sample_row(bit l, bit ob, bit cb, int unsigned ot,
                                           int unsigned ct, int unsigned el,
                                           bit typed = 1'b0, int unsigned deg = 0);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.idx = REG_MIN_ANGLE;
    r.value = 0;
    r.s.link_up = l;
    r.s.open_button = ob;
    r.s.close_button = cb;
    r.s.open_trigger = TRIG_W'(ot);
    r.s.close_trigger = TRIG_W'(ct);
    r.s.elapsed_ms = ELAPSED_W'(el);
    r.typed = typed;
    r.deg = DEG_W'(deg);
    return r;
  endfunction

  function automatic plan_row_t reg_row(reg_idx_t idx, int unsigned value);
    plan_row_t r;
    r = sample_row(1'b0, 1'b0, 1'b0, 0, 0, 0);
    r.is_reg = 1'b1;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  // Extreme low, extreme high, or anything in between
  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] random_trigger();
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 255;
      2: v = 32'(dead_zone) + $urandom_range(0, 2);
      default: v = $urandom_range(0, 255);
    endcase
    return (v > 255) ? TRIG_FULL : TRIG_W'(v);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.link_up = ($urandom_range(0, 9) != 0);
    s.open_button = ($urandom_range(0, 11) == 0);
    s.close_button = ($urandom_range(0, 11) == 0);
    s.open_trigger = random_trigger();
    s.close_trigger = random_trigger();
    case ($urandom_range(0, 3))
      0: s.elapsed_ms = ELAPSED_W'($urandom_range(0, 65535));
      1: s.elapsed_ms = ELAPSED_W'($urandom_range(0, 32'(dt_cap) + 8));
      default: s.elapsed_ms = ELAPSED_W'($urandom_range(0, 30));
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Present one sample, after a random gap, and hold it until accepted
  task automatic drive_sample(sample_t s, bit typed, logic [DEG_W-1:0] deg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(s);
    beat_typed <= typed;
    beat_deg <= deg;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending, wait for every command, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_degrees.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    apply_reg(idx, value);
  endtask

  task automatic randomize_settings();
    int unsigned lo_deg, hi_deg, t;
    settle();
    lo_deg = pick(0, 180);
    hi_deg = pick(0, 180);
    // mostly a sane range, sometimes inverted
    if ($urandom_range(0, 3) != 0 && lo_deg > hi_deg) begin
      t = lo_deg;
      lo_deg = hi_deg;
      hi_deg = t;
    end
    write_reg(REG_MIN_ANGLE, lo_deg);
    write_reg(REG_MAX_ANGLE, hi_deg);
    write_reg(REG_MAX_RATE, pick(0, 1023));
    write_reg(REG_DEADZONE, pick(0, 254));
    write_reg(REG_DT_CAP, pick(0, 255));
    cfg_we <= 1'b0;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Predict on every accepted sample
  always @(posedge clk) begin
    bit emit;
    logic [DEG_W-1:0] deg;
    if (rst_n && in_tvalid && in_tready) begin
      advance_servo(sample_t'(in_tdata[$bits(sample_t)-1:0]), emit, deg);
      if (beat_typed) pending_degrees.push_back(beat_deg);
      else if (emit) pending_degrees.push_back(deg);
    end
  end

  // Check every command beat against the oldest expectation
  always @(posedge clk) begin
    logic [DEG_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_degrees.size() == 0) begin
        report_mismatch($sformatf("command %0d with none expected", out_tdata));
      end else begin
        want = pending_degrees.pop_front();
        if (out_tdata !== want)
          report_mismatch($sformatf("servo_degrees: expected %0d, got %0d", want, out_tdata));
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    bit in_reg;
    int unsigned n;
    sample_t s;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // link down with every field high: dropped
    plan.push_back(sample_row(1, 1, 1, 255, 255, 65535));
    plan[0].s.link_up = 1'b0;
    // first sample always sends, even without motion
    plan.push_back(sample_row(1, 0, 0, 0, 0, 0, 1, 90));
    // buttons snap; close wins over open
    plan.push_back(sample_row(1, 1, 0, 0, 0, 0, 1, 175));
    plan.push_back(sample_row(1, 1, 1, 0, 0, 0, 1, 5));
    plan.push_back(sample_row(1, 1, 0, 0, 0, 0, 1, 175));
    plan.push_back(sample_row(1, 0, 1, 0, 0, 0, 1, 5));
    // full open trigger, elapsed time capped
    plan.push_back(sample_row(1, 0, 0, 255, 0, 65535));
    // one step past the deadzone: tiny move, no command
    plan.push_back(sample_row(1, 0, 0, 13, 0, 50));
    plan.push_back(sample_row(1, 0, 0, 12, 12, 40));
    // opposite full triggers cancel
    plan.push_back(sample_row(1, 0, 0, 255, 255, 50));
    plan.push_back(sample_row(1, 0, 0, 0, 255, 32768));
    plan.push_back(sample_row(1, 0, 0, 0, 255, 50));
    // snap to max, then clamp after the trigger move
    plan.push_back(sample_row(1, 1, 0, 255, 0, 50));
    plan.push_back(sample_row(1, 0, 0, 170, 85, 21845));
    // deadzone at the top of the trigger range: no trigger exceeds it
    plan.push_back(reg_row(REG_DEADZONE, 255));
    plan.push_back(sample_row(1, 0, 0, 255, 0, 50));
    plan.push_back(sample_row(1, 0, 1, 255, 255, 50, 1, 5));
    // span of one, fastest rate
    plan.push_back(reg_row(REG_DEADZONE, 254));
    plan.push_back(reg_row(REG_MAX_RATE, 1023));
    plan.push_back(sample_row(1, 0, 0, 255, 0, 50));
    // min above max: a snap is not clamped, the trigger clamp raises to min
    plan.push_back(reg_row(REG_MIN_ANGLE, 180));
    plan.push_back(reg_row(REG_MAX_ANGLE, 0));
    plan.push_back(sample_row(1, 1, 0, 0, 0, 0, 1, 0));
    plan.push_back(sample_row(1, 0, 0, 0, 255, 50));
    // zero rate and zero time cap: no motion
    plan.push_back(reg_row(REG_MIN_ANGLE, 0));
    plan.push_back(reg_row(REG_MAX_ANGLE, 180));
    plan.push_back(reg_row(REG_MAX_RATE, 0));
    plan.push_back(reg_row(REG_DEADZONE, 0));
    plan.push_back(reg_row(REG_DT_CAP, 0));
    plan.push_back(sample_row(1, 0, 0, 255, 0, 1000));
    // widest time cap with full rate: clamp at both ends
    plan.push_back(reg_row(REG_MAX_RATE, 1023));
    plan.push_back(reg_row(REG_DT_CAP, 255));
    plan.push_back(sample_row(1, 0, 0, 0, 255, 300));
    plan.push_back(sample_row(1, 0, 0, 255, 1, 300));

    in_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!in_reg) settle();
        in_reg = 1'b1;
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        if (in_reg) cfg_we <= 1'b0;
        in_reg = 1'b0;
        drive_sample(plan[i].s, plan[i].typed, plan[i].deg);
      end
    end

    // Random samples: three stall patterns, three register settings each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        randomize_settings();
        n = 0;
        while (n < ITEMS_PER_SETTING) begin
          s = random_sample();
          if (s.link_up) n++;
          drive_sample(s, 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatch_count == 0 && pending_degrees.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
